>>> rtl/core/rcpc_pkg.sv
package rcpc_pkg;

	localparam int NumWords   = 12;
	localparam int MaxWordLen = 25;
	localparam int WinDepth   = MaxWordLen - 1;
	localparam int QueryWords = 9;

	// word slots in the hit vector
	localparam int WProcClass = 0;
	localparam int WCreate    = 1;
	localparam int WSubscr    = 9;
	localparam int WLoopV4    = 10;
	localparam int WLoopV6    = 11;

	// right-justified text: byte k holds the k-th character from the end
	localparam logic [MaxWordLen*8-1:0] WordText [NumWords] = '{
		{"wi", "n32_process"},
		"create",
		"__eventconsumer",
		"__eventfilter",
		"__filtertoconsumerbinding",
		"commandlineeventconsumer",
		"activescripteventconsumer",
		{"powe", "rshell"},
		"pwsh",
		"subscription",
		"127.0.0.1",
		"::1"
	};

	localparam logic [4:0] WordLen [NumWords] = '{
		5'd13, 5'd6, 5'd15, 5'd13, 5'd25, 5'd24,
		5'd25, 5'd10, 5'd4, 5'd12, 5'd9, 5'd3
	};

	localparam logic [71:0] LocalName = "localhost";
	localparam logic [3:0]  LocalNameLen = 4'd9;
	localparam logic [15:0] CharDot = 16'h002E;
	localparam logic [15:0] CharUpA = 16'h0041;
	localparam logic [15:0] CharUpZ = 16'h005A;
	localparam logic [15:0] CaseOffset = 16'h0020;

	localparam logic [1:0] FieldNs    = 2'd0;
	localparam logic [1:0] FieldQuery = 2'd1;
	localparam logic [1:0] FieldHost  = 2'd2;

	localparam logic [1:0] OpQuery     = 2'd0;
	localparam logic [1:0] OpMethod    = 2'd1;
	localparam logic [1:0] OpSubscribe = 2'd2;
	localparam logic [1:0] OpConnect   = 2'd3;

	localparam logic [15:0] EvQuery     = 16'd11;
	localparam logic [15:0] EvMethod    = 16'd23;
	localparam logic [15:0] EvSubscribe = 16'd22;
	localparam logic [15:0] EvConnect   = 16'd5;

	typedef struct packed {
		logic [QueryWords-1:0] query_hits;
		logic                  ns_hit;
		logic [1:0]            loop_hits;
		logic [3:0]            host_len;
		logic                  dot_match;
		logic                  lname_match;
	} track_t;

	localparam track_t TrackReset = '{
		query_hits:  '0,
		ns_hit:      1'b0,
		loop_hits:   2'b00,
		host_len:    4'd0,
		dot_match:   1'b1,
		lname_match: 1'b1
	};

	typedef struct packed {
		logic       event_valid;
		logic [1:0] operation;
		logic       suspicious;
		logic       remote_host;
		logic       process_create_hit;
		logic       persistence_hit;
		logic       shell_hit;
		logic       subscription_ns_hit;
	} result_t;

endpackage

>>> rtl/core/rcpc_window.sv
module rcpc_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic                          clear_all,
	input  logic                          fld_chg,
	input  logic                          shift_in,
	input  logic [15:0]                   unit_lc,
	output logic [rcpc_pkg::NumWords-1:0] hits
);

	logic [15:0] win_q [rcpc_pkg::WinDepth];
	logic [15:0] base  [rcpc_pkg::WinDepth];
	logic [15:0] view  [rcpc_pkg::MaxWordLen];

	// drop the old text when the field changes, newest unit in front
	always_comb begin
		for (int i = 0; i < rcpc_pkg::WinDepth; i++) begin
			base[i] = fld_chg ? 16'h0000 : win_q[i];
		end
		view[0] = unit_lc;
		for (int i = 1; i < rcpc_pkg::MaxWordLen; i++) begin
			view[i] = base[i-1];
		end
	end

	always_comb begin
		for (int w = 0; w < rcpc_pkg::NumWords; w++) begin
			hits[w] = 1'b1;
			for (int k = 0; k < rcpc_pkg::MaxWordLen; k++) begin
				if (k < rcpc_pkg::WordLen[w] &&
				    view[k] != {8'h00, rcpc_pkg::WordText[w][8*k +: 8]}) begin
					hits[w] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rcpc_pkg::WinDepth; i++) win_q[i] <= 16'h0000;
		end else if (upd) begin
			if (clear_all) begin
				for (int i = 0; i < rcpc_pkg::WinDepth; i++) win_q[i] <= 16'h0000;
			end else if (shift_in) begin
				win_q[0] <= unit_lc;
				for (int i = 1; i < rcpc_pkg::WinDepth; i++) win_q[i] <= base[i-1];
			end else begin
				for (int i = 0; i < rcpc_pkg::WinDepth; i++) win_q[i] <= base[i];
			end
		end
	end

endmodule

>>> rtl/core/rcpc_verdict.sv
module rcpc_verdict (
	input  rcpc_pkg::track_t  trk,
	input  logic [15:0]       event_number,
	output rcpc_pkg::result_t res
);

	logic       known;
	logic [1:0] op;
	logic       pc, pe, sh, ns, remote;

	always_comb begin
		known = 1'b1;
		op    = rcpc_pkg::OpQuery;
		case (event_number)
			rcpc_pkg::EvQuery:     op = rcpc_pkg::OpQuery;
			rcpc_pkg::EvMethod:    op = rcpc_pkg::OpMethod;
			rcpc_pkg::EvSubscribe: op = rcpc_pkg::OpSubscribe;
			rcpc_pkg::EvConnect:   op = rcpc_pkg::OpConnect;
			default:               known = 1'b0;
		endcase
	end

	assign pc = trk.query_hits[rcpc_pkg::WProcClass] && trk.query_hits[rcpc_pkg::WCreate];
	assign pe = |trk.query_hits[6:2];
	assign sh = |trk.query_hits[8:7];
	assign ns = trk.ns_hit;
	assign remote = (trk.host_len != 4'd0)
		&& !(trk.dot_match && trk.host_len == 4'd1)
		&& !(trk.lname_match && trk.host_len == rcpc_pkg::LocalNameLen)
		&& (trk.loop_hits == 2'b00);

	// an unknown event reports nothing at all
	always_comb begin
		res.event_valid         = known;
		res.operation           = known ? op : rcpc_pkg::OpQuery;
		res.suspicious          = known && (pc || pe || sh || ns || remote);
		res.remote_host         = known && remote;
		res.process_create_hit  = known && pc;
		res.persistence_hit     = known && pe;
		res.shell_hit           = known && sh;
		res.subscription_ns_hit = known && ns;
	end

endmodule

>>> rtl/core/remote_call_pattern_classifier.sv
// Channel  Direction  Handshake            Transaction
// input    in         in_valid / in_stall  one code unit of a field, end-of-event mark
// output   out        out_valid / out_stall one verdict per end-of-event item
//
// One item per cycle unless an end-of-event item waits on an untaken verdict. Items pass
// an input register, then the window compare and state update that closes the loop on
// the window and per-event hit registers; verdicts are offered from a result register.
// Reset clears the window, the field tracker, the hit registers and both valids.
// in_stall rises only while an end-of-event item waits for a result register that
// still holds an untaken verdict.
module remote_call_pattern_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  field_id,
	input  logic [15:0] code_unit,
	input  logic        has_unit,
	input  logic        end_of_event,
	input  logic [15:0] event_number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        event_valid,
	output logic [1:0]  operation,
	output logic        suspicious,
	output logic        remote_host,
	output logic        process_create_hit,
	output logic        persistence_hit,
	output logic        shell_hit,
	output logic        subscription_ns_hit
);

	logic        valid_s1;
	logic [1:0]  field_s1;
	logic [15:0] unit_s1;
	logic        has_s1;
	logic        eoe_s1;
	logic [15:0] evnum_s1;

	logic              res_valid_s2;
	rcpc_pkg::result_t res_s2;
	rcpc_pkg::result_t res_nxt;

	logic [1:0]       cur_field_q;
	rcpc_pkg::track_t trk_q;
	rcpc_pkg::track_t trk_nxt;

	logic                          go;
	logic                          accept;
	logic                          fld_chg;
	logic [15:0]                   unit_lc;
	logic [rcpc_pkg::NumWords-1:0] hits;
	logic [3:0]                    lname_pos;
	logic [7:0]                    lname_ch;

	assign go       = valid_s1 && (!eoe_s1 || !res_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !go;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			field_s1 <= field_id;
			unit_s1  <= code_unit;
			has_s1   <= has_unit;
			eoe_s1   <= end_of_event;
			evnum_s1 <= event_number;
		end
	end

	assign fld_chg = field_s1 != cur_field_q;
	assign unit_lc = (unit_s1 >= rcpc_pkg::CharUpA && unit_s1 <= rcpc_pkg::CharUpZ)
		? unit_s1 + rcpc_pkg::CaseOffset : unit_s1;

	rcpc_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (go),
		.clear_all (eoe_s1),
		.fld_chg   (fld_chg),
		.shift_in  (has_s1),
		.unit_lc   (unit_lc),
		.hits      (hits)
	);

	// exact host compare runs on the raw unit, not the folded one
	assign lname_pos = (trk_q.host_len < rcpc_pkg::LocalNameLen)
		? 4'd8 - trk_q.host_len : 4'd0;
	assign lname_ch  = rcpc_pkg::LocalName[{lname_pos, 3'b000} +: 8];

	always_comb begin
		trk_nxt = trk_q;
		if (has_s1) begin
			case (field_s1)
				rcpc_pkg::FieldQuery: begin
					trk_nxt.query_hits = trk_q.query_hits | hits[rcpc_pkg::QueryWords-1:0];
				end
				rcpc_pkg::FieldNs: begin
					trk_nxt.ns_hit = trk_q.ns_hit | hits[rcpc_pkg::WSubscr];
				end
				rcpc_pkg::FieldHost: begin
					trk_nxt.loop_hits = trk_q.loop_hits
						| {hits[rcpc_pkg::WLoopV6], hits[rcpc_pkg::WLoopV4]};
					if (trk_q.host_len != 4'd0 || unit_s1 != rcpc_pkg::CharDot) begin
						trk_nxt.dot_match = 1'b0;
					end
					if (trk_q.host_len >= rcpc_pkg::LocalNameLen ||
					    unit_s1 != {8'h00, lname_ch}) begin
						trk_nxt.lname_match = 1'b0;
					end
					if (trk_q.host_len != 4'hF) begin
						trk_nxt.host_len = trk_q.host_len + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	rcpc_verdict u_verdict (
		.trk          (trk_nxt),
		.event_number (evnum_s1),
		.res          (res_nxt)
	);

	// end of event: return all tracking to its idle value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_field_q <= rcpc_pkg::FieldNs;
			trk_q       <= rcpc_pkg::TrackReset;
		end else if (go) begin
			cur_field_q <= eoe_s1 ? rcpc_pkg::FieldNs : field_s1;
			trk_q       <= eoe_s1 ? rcpc_pkg::TrackReset : trk_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (go && eoe_s1) begin
			res_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && eoe_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid           = res_valid_s2;
	assign event_valid         = res_s2.event_valid;
	assign operation           = res_s2.operation;
	assign suspicious          = res_s2.suspicious;
	assign remote_host         = res_s2.remote_host;
	assign process_create_hit  = res_s2.process_create_hit;
	assign persistence_hit     = res_s2.persistence_hit;
	assign shell_hit           = res_s2.shell_hit;
	assign subscription_ns_hit = res_s2.subscription_ns_hit;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && eoe_s1 && res_valid_s2 && out_stall)
		else $error("input stalled without a blocked verdict");

	a_event_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && eoe_s1 |=> cur_field_q == rcpc_pkg::FieldNs && trk_q == rcpc_pkg::TrackReset)
		else $error("tracking state not cleared after end of event");

	a_unknown_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !event_valid |-> !suspicious && !remote_host
			&& !process_create_hit && !persistence_hit && !shell_hit
			&& !subscription_ns_hit && operation == rcpc_pkg::OpQuery)
		else $error("unknown event reports hits");

	a_susp_cover: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_valid |-> suspicious == (remote_host || process_create_hit
			|| persistence_hit || shell_hit || subscription_ns_hit))
		else $error("suspicious flag disagrees with rule hits");

endmodule
